// ===== rtl/sdhs_pkg.sv =====
package sdhs_pkg;

	localparam int MODE_W   = 3;
	localparam int SLOT_W   = 8;
	localparam int STATUS_W = 2;
	localparam int CIDX_W   = 3;
	localparam int CDATA_W  = 24;

	localparam int HALF_W   = 16;
	localparam int SETTLE_W = 16;
	localparam int PAUSE_W  = 24;
	localparam int TRAVEL_W = 20;
	localparam int SLOTC_W  = 7;
	localparam int BASE_W   = 16;
	localparam int SPS_W    = 12;
	localparam int BACK_W   = 12;
	localparam int TICK_W   = 24;
	localparam int STEP_W   = 20;
	localparam int TARGET_W = 19;
	localparam int PROD_W   = 21;

	localparam logic [HALF_W-1:0]   HALF_RST   = 16'd500;
	localparam logic [SETTLE_W-1:0] SETTLE_RST = 16'd50;
	localparam logic [PAUSE_W-1:0]  PAUSE_RST  = 24'd200000;
	localparam logic [TRAVEL_W-1:0] TRAVEL_RST = 20'd50000;
	localparam logic [SLOTC_W-1:0]  SLOTC_RST  = 7'd16;
	localparam logic [BASE_W-1:0]   BASE_RST   = 16'd400;
	localparam logic [SPS_W-1:0]    SPS_RST    = 12'd600;
	localparam logic [BACK_W-1:0]   BACK_RST   = 12'd50;
	localparam logic [TARGET_W-1:0] TARGET_MAX = '1;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK     = 3'd0,
		MODE_DISPENSE = 3'd1,
		MODE_HOME     = 3'd2,
		MODE_ABORT    = 3'd3,
		MODE_CLEAR    = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_BADSLOT = 2'd1,
		ST_ABORT   = 2'd2,
		ST_OVERRUN = 2'd3
	} status_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_HALF   = 3'd0,
		CFG_SETTLE = 3'd1,
		CFG_PAUSE  = 3'd2,
		CFG_TRAVEL = 3'd3,
		CFG_SLOTC  = 3'd4,
		CFG_BASE   = 3'd5,
		CFG_SPS    = 3'd6,
		CFG_BACK   = 3'd7
	} cfg_idx_t;

endpackage

// ===== rtl/sdhs_if.sv =====
interface sdhs_cmd_if import sdhs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [SLOT_W-1:0] slot_number;
	logic              limit_switch;

	modport source (output valid, mode, slot_number, limit_switch, input ready);
	modport sink (input valid, mode, slot_number, limit_switch, output ready);
endinterface

interface sdhs_res_if import sdhs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                step_level;
	logic                direction_level;
	logic                disable_level;
	logic                busy_res;
	logic                done_res;
	logic [STATUS_W-1:0] status;
	logic                abort_pending;

	modport source (output valid, step_level, direction_level, disable_level, busy_res,
		done_res, status, abort_pending, input ready);
	modport sink (input valid, step_level, direction_level, disable_level, busy_res,
		done_res, status, abort_pending, output ready);
endinterface

interface sdhs_cfg_if import sdhs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CIDX_W-1:0]  index;
	logic [CDATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/stepper_dispense_homing_sequencer.sv =====
// An accepted item waits in the input register until the result register is free or read,
// then its result is registered. Throughput: one item per cycle while each result is taken;
// while a result waits, the input register holds its item. Sequencer state updates with the
// result register, so each item sees all earlier items; config takes cfg writes on its own.
// Reset (arst_n low) loads config defaults, idles the sequencer, clears abort, disables the motor.
module stepper_dispense_homing_sequencer import sdhs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sdhs_cmd_if.sink    cmd,
	sdhs_res_if.source  res,
	sdhs_cfg_if.sink    cfg
);

	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_PAUSE       = 4'd1,
		PH_FWD_SETTLE  = 4'd2,
		PH_FWD_PULSE   = 4'd3,
		PH_REV_SETTLE  = 4'd4,
		PH_REV_PULSE   = 4'd5,
		PH_HOME_SETTLE = 4'd6,
		PH_HOME_PULSE  = 4'd7,
		PH_BACK_SETTLE = 4'd8,
		PH_BACK_PULSE  = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		K_FWD  = 2'd0,
		K_REV  = 2'd1,
		K_HOME = 2'd2,
		K_BACK = 2'd3
	} kind_t;

	// config
	logic [HALF_W-1:0]   half_q;
	logic [SETTLE_W-1:0] settle_q;
	logic [PAUSE_W-1:0]  pause_q;
	logic [TRAVEL_W-1:0] travel_q;
	logic [SLOTC_W-1:0]  slotc_q;
	logic [BASE_W-1:0]   base_q;
	logic [SPS_W-1:0]    sps_q;
	logic [BACK_W-1:0]   back_q;

	// input stage
	logic              valid_s1;
	logic [MODE_W-1:0] mode_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              limit_s1;

	// sequencer state
	phase_t              phase_q;
	logic [TICK_W-1:0]   tick_q;
	logic [STEP_W-1:0]   step_q;
	logic [TARGET_W-1:0] target_q;
	logic                pulse_q;
	logic                dir_q;
	logic                dis_q;
	logic                abort_q;

	// result register
	logic                ov_q;
	logic                step_lvl_q;
	logic                dir_lvl_q;
	logic                dis_lvl_q;
	logic                busy_q;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic                abort_lvl_q;

	logic adv;

	phase_t              n_phase;
	logic [TICK_W-1:0]   n_tick;
	logic [STEP_W-1:0]   n_step;
	logic [TARGET_W-1:0] n_target;
	logic                n_pulse;
	logic                n_dir;
	logic                n_dis;
	logic                n_abort;
	logic                started;
	logic                fin;
	status_t             fin_st;
	logic                chk;
	logic                bm;
	kind_t               bm_kind;
	kind_t               kind;
	logic [3:0]          pm2;
	logic [TICK_W-1:0]   t1;
	logic [STEP_W-1:0]   goal;
	logic [PROD_W-1:0]   tgt_full;
	logic [TARGET_W-1:0] tgt_sat;
	logic                bad_slot;

	assign adv       = valid_s1 && (!ov_q || res.ready);
	assign cmd.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q   <= HALF_RST;
			settle_q <= SETTLE_RST;
			pause_q  <= PAUSE_RST;
			travel_q <= TRAVEL_RST;
			slotc_q  <= SLOTC_RST;
			base_q   <= BASE_RST;
			sps_q    <= SPS_RST;
			back_q   <= BACK_RST;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_HALF:   half_q   <= cfg.data[HALF_W-1:0];
				CFG_SETTLE: settle_q <= cfg.data[SETTLE_W-1:0];
				CFG_PAUSE:  pause_q  <= cfg.data[PAUSE_W-1:0];
				CFG_TRAVEL: travel_q <= cfg.data[TRAVEL_W-1:0];
				CFG_SLOTC:  slotc_q  <= cfg.data[SLOTC_W-1:0];
				CFG_BASE:   base_q   <= cfg.data[BASE_W-1:0];
				CFG_SPS:    sps_q    <= cfg.data[SPS_W-1:0];
				CFG_BACK:   back_q   <= cfg.data[BACK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			mode_s1  <= cmd.mode;
			slot_s1  <= cmd.slot_number;
			limit_s1 <= cmd.limit_switch;
		end
	end

	assign tgt_full = PROD_W'(slot_s1) * PROD_W'(sps_q) + PROD_W'(base_q);
	assign tgt_sat  = (tgt_full > PROD_W'(TARGET_MAX)) ? TARGET_MAX : tgt_full[TARGET_W-1:0];
	assign bad_slot = (slot_s1 == '0) || (slot_s1 > SLOT_W'(slotc_q));
	assign pm2      = 4'(phase_q - PH_FWD_SETTLE);
	assign kind     = kind_t'(pm2[2:1]);
	assign t1       = tick_q + TICK_W'(1);

	always_comb begin
		n_phase  = phase_q;
		n_tick   = tick_q;
		n_step   = step_q;
		n_target = target_q;
		n_pulse  = pulse_q;
		n_dir    = dir_q;
		n_dis    = dis_q;
		n_abort  = abort_q;
		started  = 1'b0;
		fin      = 1'b0;
		fin_st   = ST_OK;
		chk      = 1'b0;
		bm       = 1'b0;
		bm_kind  = K_FWD;
		goal     = '0;

		case (mode_s1)
			MODE_ABORT: begin
				n_abort = 1'b1;
				n_dis   = 1'b1;
			end
			MODE_CLEAR: begin
				n_abort = 1'b0;
			end
			MODE_DISPENSE: begin
				if (phase_q == PH_IDLE) begin
					started = 1'b1;
					if (bad_slot) begin
						fin    = 1'b1;
						fin_st = ST_BADSLOT;
					end else begin
						n_target = tgt_sat;
						bm       = 1'b1;
						bm_kind  = K_FWD;
					end
				end
			end
			MODE_HOME: begin
				if (phase_q == PH_IDLE) begin
					started = 1'b1;
					n_step  = '0;
					n_tick  = '0;
					n_pulse = 1'b0;
					n_dis   = 1'b0;
					n_dir   = 1'b0;
					n_phase = PH_HOME_SETTLE;
				end
			end
			default: ;
		endcase

		if (!started && phase_q != PH_IDLE) begin
			if (phase_q == PH_PAUSE) begin
				if (tick_q >= pause_q) begin
					bm      = 1'b1;
					bm_kind = K_REV;
				end else begin
					n_tick = t1;
				end
			end else if (phase_q > PH_BACK_PULSE) begin
				n_phase = PH_IDLE;
			end else if (!phase_q[0]) begin
				if (tick_q >= TICK_W'(settle_q))
					chk = 1'b1;
				else
					n_tick = t1;
			end else if (t1 < TICK_W'(half_q)) begin
				n_tick = t1;
			end else if (pulse_q) begin
				n_pulse = 1'b0;
				n_tick  = '0;
			end else if (kind == K_HOME && step_q >= travel_q) begin
				n_dis  = 1'b1;
				fin    = 1'b1;
				fin_st = ST_OVERRUN;
			end else begin
				n_step = step_q + STEP_W'(1);
				chk    = 1'b1;
			end
		end

		// step boundary: goal, limit and abort checks, else start the next pulse
		if (chk) begin
			goal = (kind == K_BACK) ? STEP_W'(back_q) : STEP_W'(target_q);
			if (kind == K_HOME && limit_s1) begin
				bm      = 1'b1;
				bm_kind = K_BACK;
			end else if (kind != K_HOME && n_step >= goal) begin
				case (kind)
					K_FWD: begin
						n_phase = PH_PAUSE;
						n_tick  = '0;
					end
					K_REV: begin
						n_step  = '0;
						n_tick  = '0;
						n_pulse = 1'b0;
						n_dis   = 1'b0;
						n_dir   = 1'b0;
						n_phase = PH_HOME_SETTLE;
					end
					default: begin
						n_dis  = 1'b1;
						fin    = 1'b1;
						fin_st = ST_OK;
					end
				endcase
			end else if (n_abort) begin
				n_dis  = 1'b1;
				fin    = 1'b1;
				fin_st = (kind == K_BACK) ? ST_OK : ST_ABORT;
			end else begin
				n_pulse = 1'b1;
				n_tick  = '0;
				n_phase = phase_t'(4'({kind, 1'b0}) + 4'd3);
			end
		end

		if (bm) begin
			n_step  = '0;
			n_tick  = '0;
			n_pulse = 1'b0;
			if (n_abort) begin
				n_dis  = 1'b1;
				fin    = 1'b1;
				fin_st = (bm_kind == K_BACK) ? ST_OK : ST_ABORT;
			end else begin
				n_dis   = 1'b0;
				n_dir   = (bm_kind != K_REV);
				n_phase = phase_t'(4'({bm_kind, 1'b0}) + 4'd2);
			end
		end

		if (fin) begin
			n_phase = PH_IDLE;
			n_pulse = 1'b0;
			n_tick  = '0;
			n_step  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			step_q      <= '0;
			target_q    <= '0;
			pulse_q     <= 1'b0;
			dir_q       <= 1'b0;
			dis_q       <= 1'b1;
			abort_q     <= 1'b0;
			ov_q        <= 1'b0;
			step_lvl_q  <= 1'b0;
			dir_lvl_q   <= 1'b0;
			dis_lvl_q   <= 1'b1;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
			abort_lvl_q <= 1'b0;
		end else begin
			if (adv) begin
				phase_q     <= n_phase;
				tick_q      <= n_tick;
				step_q      <= n_step;
				target_q    <= n_target;
				pulse_q     <= n_pulse;
				dir_q       <= n_dir;
				dis_q       <= n_dis;
				abort_q     <= n_abort;
				step_lvl_q  <= n_pulse;
				dir_lvl_q   <= n_dir;
				dis_lvl_q   <= n_dis;
				busy_q      <= (n_phase != PH_IDLE);
				done_q      <= fin;
				status_q    <= fin ? fin_st : ST_OK;
				abort_lvl_q <= n_abort;
				ov_q        <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign res.valid           = ov_q;
	assign res.step_level      = step_lvl_q;
	assign res.direction_level = dir_lvl_q;
	assign res.disable_level   = dis_lvl_q;
	assign res.busy_res        = busy_q;
	assign res.done_res        = done_q;
	assign res.status          = status_q;
	assign res.abort_pending   = abort_lvl_q;

`ifndef SYNTHESIS
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && done_q |-> !busy_q)
		else $error("done with sequence still busy");

	a_status_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && (status_q != ST_OK) |-> done_q)
		else $error("status set without done");

	a_step_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && step_lvl_q |-> busy_q)
		else $error("step pulse while idle");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(mode_s1))
		else $error("input stage lost an item");
`endif

endmodule
